// ===== rtl/mbxs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbxs_pkg
// Shared types, character codes and result-burst helpers for the mboxrd
// message splitter.
// ----------------------------------------------------------------------------
package mbxs_pkg;

   localparam int BYTE_W = 8;
   localparam int REP_W  = 16;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR_FROM  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERR_EMPTY = 2'd3;

   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;

   localparam logic [2:0] FROM_LEN = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] out_byte;
      logic [REP_W-1:0]  repeat_res;
      logic              last_of_run;
   } rsp_word_type;

   // All results of one input byte, in output order:
   // blank run, '>' run, "From " letters, the byte, leftover blank run, terminal.
   typedef struct packed {
      logic              blank_en;
      logic [REP_W-1:0]  blank_rep;
      logic              quote_en;
      logic [REP_W-1:0]  quote_rep;
      logic [2:0]        letter_cnt;
      logic              byte_en;
      logic [BYTE_W-1:0] byte_val;
      logic              tail_en;
      logic [REP_W-1:0]  tail_rep;
      logic              term_en;
      logic [KIND_W-1:0] term_kind;
   } burst_type;

   function automatic logic [BYTE_W-1:0] from_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0: c = 8'h46;   // F
         3'd1: c = 8'h72;   // r
         3'd2: c = 8'h6F;   // o
         3'd3: c = 8'h6D;   // m
         3'd4: c = 8'h20;   // space
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] burst_count(input burst_type t);
      return {3'b0, t.blank_en} + {3'b0, t.quote_en} + {1'b0, t.letter_cnt}
           + {3'b0, t.byte_en} + {3'b0, t.tail_en} + {3'b0, t.term_en};
   endfunction

   function automatic rsp_word_type burst_entry(input burst_type t, input logic [2:0] idx);
      rsp_word_type w;
      logic [3:0]   j;
      logic [3:0]   o_quote;
      logic [3:0]   o_let;
      logic [3:0]   o_byte;
      logic [3:0]   o_tail;
      logic [3:0]   o_term;
      logic [3:0]   rel;
      j       = {1'b0, idx};
      o_quote = {3'b0, t.blank_en};
      o_let   = o_quote + {3'b0, t.quote_en};
      o_byte  = o_let + {1'b0, t.letter_cnt};
      o_tail  = o_byte + {3'b0, t.byte_en};
      o_term  = o_tail + {3'b0, t.tail_en};
      rel     = j - o_let;
      w       = '0;
      if (t.blank_en && j == 4'd0) begin
         w.kind       = KIND_DATA;
         w.out_byte   = CH_LF;
         w.repeat_res = t.blank_rep;
      end else if (t.quote_en && j == o_quote) begin
         w.kind       = KIND_DATA;
         w.out_byte   = CH_GT;
         w.repeat_res = t.quote_rep;
      end else if (j >= o_let && j < o_byte) begin
         w.kind       = KIND_DATA;
         w.out_byte   = from_char(rel[2:0]);
         w.repeat_res = 16'd1;
      end else if (t.byte_en && j == o_byte) begin
         w.kind       = KIND_DATA;
         w.out_byte   = t.byte_val;
         w.repeat_res = 16'd1;
      end else if (t.tail_en && j == o_tail) begin
         w.kind       = KIND_DATA;
         w.out_byte   = CH_LF;
         w.repeat_res = t.tail_rep;
      end else if (t.term_en && j == o_term) begin
         w.kind       = t.term_kind;
      end
      w.last_of_run = (j + 4'd1 == burst_count(t));
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mbxs_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbxs_line_parser
// Per-byte line state machine: tracks line phase, '>' depth, "From " match
// and held blank lines, and builds the result burst for each accepted word.
// ----------------------------------------------------------------------------
module mbxs_line_parser #(
   parameter int MAX_QUOTE_DEPTH    = 255,
   parameter int MAX_PENDING_BLANKS = 65535
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_fire,
   input  mbxs_pkg::req_word_type  req_data,
   output logic                    burst_load,
   output mbxs_pkg::burst_type     burst
);

   localparam int QD_W = $clog2(MAX_QUOTE_DEPTH + 1);
   localparam int PB_W = $clog2(MAX_PENDING_BLANKS + 1);

   localparam logic [3:0] PH_PRE_START  = 4'd0;
   localparam logic [3:0] PH_PRE_BLANK  = 4'd1;
   localparam logic [3:0] PH_PRE_MATCH  = 4'd2;
   localparam logic [3:0] PH_PRE_TAIL   = 4'd3;
   localparam logic [3:0] PH_LINE_START = 4'd4;
   localparam logic [3:0] PH_BLANK      = 4'd5;
   localparam logic [3:0] PH_PREFIX     = 4'd6;
   localparam logic [3:0] PH_PASS       = 4'd7;
   localparam logic [3:0] PH_SEP_TAIL   = 4'd8;
   localparam logic [3:0] PH_HALT       = 4'd9;

   logic [3:0]      phase_ff, phase_in;
   logic [QD_W-1:0] qd_ff, qd_in;
   logic [2:0]      mp_ff, mp_in;
   logic [PB_W-1:0] pb_ff, pb_in;
   logic            has_ff, has_in;

   mbxs_pkg::burst_type burst_in;

   logic [7:0]      b;
   logic            is_lf, is_cr, is_gt;
   logic            pb_many;
   logic            do_prefix;
   logic [QD_W-1:0] pfx_qd;
   logic [2:0]      pfx_mp;

   assign b       = req_data.in_byte;
   assign is_lf   = (b == mbxs_pkg::CH_LF);
   assign is_cr   = (b == mbxs_pkg::CH_CR);
   assign is_gt   = (b == mbxs_pkg::CH_GT);
   assign pb_many = (pb_ff > PB_W'(1));

   always_comb begin
      phase_in  = phase_ff;
      qd_in     = qd_ff;
      mp_in     = mp_ff;
      pb_in     = pb_ff;
      has_in    = has_ff;
      burst_in  = '0;
      do_prefix = 1'b0;
      pfx_qd    = qd_ff;
      pfx_mp    = mp_ff;

      if (req_data.end_of_input) begin
         case (phase_ff)
            PH_PRE_START, PH_PRE_BLANK, PH_PRE_MATCH: begin
               burst_in.term_en   = 1'b1;
               burst_in.term_kind = mbxs_pkg::KIND_ERR_FROM;
            end
            PH_PRE_TAIL: begin
               burst_in.term_en   = 1'b1;
               burst_in.term_kind = mbxs_pkg::KIND_ERR_EMPTY;
            end
            PH_PREFIX: begin
               // unfinished line written as plain text, then message end
               burst_in.blank_en   = (pb_ff != '0);
               burst_in.blank_rep  = 16'(pb_ff);
               burst_in.quote_en   = (qd_ff != '0);
               burst_in.quote_rep  = 16'(qd_ff);
               burst_in.letter_cnt = mp_ff;
               burst_in.term_en    = 1'b1;
               burst_in.term_kind  = mbxs_pkg::KIND_END;
            end
            PH_LINE_START, PH_BLANK, PH_PASS: begin
               burst_in.tail_en   = pb_many;
               burst_in.tail_rep  = 16'(pb_ff) - 16'd1;
               burst_in.term_en   = 1'b1;
               burst_in.term_kind = (has_ff || pb_many) ? mbxs_pkg::KIND_END
                                                        : mbxs_pkg::KIND_ERR_EMPTY;
            end
            default: begin
            end
         endcase
         phase_in = PH_HALT;
         qd_in    = '0;
         mp_in    = '0;
      end else begin
         case (phase_ff)
            PH_PRE_START: begin
               if (is_lf) begin
               end else if (is_cr) begin
                  phase_in = PH_PRE_BLANK;
               end else if (b == mbxs_pkg::from_char(3'd0)) begin
                  mp_in    = 3'd1;
                  phase_in = PH_PRE_MATCH;
               end else begin
                  burst_in.term_en   = 1'b1;
                  burst_in.term_kind = mbxs_pkg::KIND_ERR_FROM;
                  mp_in              = '0;
                  phase_in           = PH_HALT;
               end
            end
            PH_PRE_MATCH: begin
               if (b == mbxs_pkg::from_char(mp_ff)) begin
                  if (mp_ff == mbxs_pkg::FROM_LEN - 3'd1) begin
                     mp_in    = '0;
                     phase_in = PH_PRE_TAIL;
                  end else begin
                     mp_in = mp_ff + 3'd1;
                  end
               end else begin
                  burst_in.term_en   = 1'b1;
                  burst_in.term_kind = mbxs_pkg::KIND_ERR_FROM;
                  mp_in              = '0;
                  phase_in           = PH_HALT;
               end
            end
            PH_PRE_BLANK: begin
               if (is_lf) phase_in = PH_PRE_START;
            end
            PH_PRE_TAIL, PH_SEP_TAIL: begin
               if (is_lf) begin
                  pb_in    = '0;
                  has_in   = 1'b0;
                  phase_in = PH_LINE_START;
               end
            end
            PH_LINE_START: begin
               if (is_lf || is_cr) begin
                  if (pb_ff < PB_W'(MAX_PENDING_BLANKS)) pb_in = pb_ff + PB_W'(1);
                  if (is_cr) phase_in = PH_BLANK;
               end else begin
                  do_prefix = 1'b1;
                  pfx_qd    = '0;
                  pfx_mp    = '0;
               end
            end
            PH_BLANK: begin
               if (is_lf) phase_in = PH_LINE_START;
            end
            PH_PREFIX: begin
               do_prefix = 1'b1;
            end
            PH_PASS: begin
               burst_in.byte_en  = 1'b1;
               burst_in.byte_val = b;
               has_in            = 1'b1;
               if (is_lf) phase_in = PH_LINE_START;
            end
            default: begin
            end
         endcase

         // line prefix: '>' run, then "From " match, held until resolved
         if (do_prefix) begin
            phase_in = PH_PREFIX;
            qd_in    = pfx_qd;
            mp_in    = pfx_mp;
            if (pfx_mp == 3'd0 && is_gt) begin
               if (pfx_qd < QD_W'(MAX_QUOTE_DEPTH)) qd_in = pfx_qd + QD_W'(1);
            end else if (b == mbxs_pkg::from_char(pfx_mp)) begin
               if (pfx_mp != mbxs_pkg::FROM_LEN - 3'd1) begin
                  mp_in = pfx_mp + 3'd1;
               end else begin
                  mp_in = '0;
                  if (pfx_qd == '0) begin
                     // separator: close message, last held blank dropped
                     burst_in.tail_en  = pb_many;
                     burst_in.tail_rep = 16'(pb_ff) - 16'd1;
                     burst_in.term_en  = 1'b1;
                     pb_in             = '0;
                     if (has_ff || pb_many) begin
                        burst_in.term_kind = mbxs_pkg::KIND_END;
                        has_in             = 1'b0;
                        phase_in           = PH_SEP_TAIL;
                     end else begin
                        burst_in.term_kind = mbxs_pkg::KIND_ERR_EMPTY;
                        phase_in           = PH_HALT;
                     end
                  end else begin
                     // quoted From: one '>' removed
                     burst_in.blank_en   = (pb_ff != '0);
                     burst_in.blank_rep  = 16'(pb_ff);
                     burst_in.quote_en   = (pfx_qd > QD_W'(1));
                     burst_in.quote_rep  = 16'(pfx_qd) - 16'd1;
                     burst_in.letter_cnt = mbxs_pkg::FROM_LEN;
                     pb_in               = '0;
                     has_in              = 1'b1;
                     qd_in               = '0;
                     phase_in            = PH_PASS;
                  end
               end
            end else begin
               // plain line: release held prefix and this byte
               burst_in.blank_en   = (pb_ff != '0);
               burst_in.blank_rep  = 16'(pb_ff);
               burst_in.quote_en   = (pfx_qd != '0);
               burst_in.quote_rep  = 16'(pfx_qd);
               burst_in.letter_cnt = pfx_mp;
               burst_in.byte_en    = 1'b1;
               burst_in.byte_val   = b;
               pb_in               = '0;
               has_in              = 1'b1;
               qd_in               = '0;
               mp_in               = '0;
               phase_in            = is_lf ? PH_LINE_START : PH_PASS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE_START;
         qd_ff    <= '0;
         mp_ff    <= '0;
         pb_ff    <= '0;
         has_ff   <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         qd_ff    <= qd_in;
         mp_ff    <= mp_in;
         pb_ff    <= pb_in;
         has_ff   <= has_in;
      end
   end

   assign burst      = burst_in;
   assign burst_load = req_fire && (mbxs_pkg::burst_count(burst_in) != 4'd0);

endmodule
`default_nettype wire

// ===== rtl/mbxs_result_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbxs_result_buffer
// Two-deep burst buffer: the output burst is walked one result word per cycle
// while rsp_ready is high; a second burst waits behind it so input flows.
// ----------------------------------------------------------------------------
module mbxs_result_buffer (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     burst_load,
   input  mbxs_pkg::burst_type     burst,
   output logic                    slot_free,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output mbxs_pkg::rsp_word_type  rsp_data
);

   mbxs_pkg::burst_type cur_ff, cur_in;
   mbxs_pkg::burst_type pend_ff, pend_in;
   logic                busy_ff, busy_in;
   logic                pend_v_ff, pend_v_in;
   logic [2:0]          idx_ff, idx_in;

   mbxs_pkg::rsp_word_type word;
   logic [3:0]             cur_total;
   logic                   fire;
   logic                   out_free;

   assign word      = mbxs_pkg::burst_entry(cur_ff, idx_ff);
   assign cur_total = mbxs_pkg::burst_count(cur_ff);
   assign fire      = busy_ff && rsp_ready;
   assign out_free  = !busy_ff || (fire && word.last_of_run);

   always_comb begin
      cur_in    = cur_ff;
      pend_in   = pend_ff;
      busy_in   = busy_ff;
      pend_v_in = pend_v_ff;
      idx_in    = idx_ff;
      if (out_free) begin
         if (pend_v_ff) begin
            cur_in    = pend_ff;
            busy_in   = 1'b1;
            idx_in    = '0;
            pend_v_in = 1'b0;
         end else if (burst_load) begin
            cur_in  = burst;
            busy_in = 1'b1;
            idx_in  = '0;
         end else begin
            busy_in = 1'b0;
         end
      end else begin
         if (fire) idx_in = idx_ff + 3'd1;
         if (burst_load) begin
            pend_in   = burst;
            pend_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         pend_v_ff <= pend_v_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
   end

   assign slot_free = !pend_v_ff;
   assign rsp_valid = busy_ff;
   assign rsp_data  = word;

   a_pend_behind_busy: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> busy_ff)
      else $error("waiting burst without an active burst");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, idx_ff} < cur_total))
      else $error("result index past end of burst");

   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_data.kind != mbxs_pkg::KIND_DATA) |-> rsp_data.last_of_run)
      else $error("message end or error word not last of its burst");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> !pend_v_ff)
      else $error("burst loaded while both slots are full");

endmodule
`default_nettype wire

// ===== rtl/mboxrd_message_splitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mboxrd_message_splitter_top
// Splits an mboxrd byte stream into messages: data runs, message ends and
// errors.
// ----------------------------------------------------------------------------
// One input word (a text byte or end of input) is taken per cycle while a
// buffer slot is free. A byte produces zero to seven result words; the output
// side sends one result word per cycle while rsp_ready is high. The result
// buffer keeps one burst behind the one being sent, so an input word is still
// taken while a result waits on rsp_ready; input stalls only when both buffer
// slots are full. After an error or the final message end the block produces
// nothing more until reset.
// ----------------------------------------------------------------------------
module mboxrd_message_splitter_top #(
   parameter int MAX_QUOTE_DEPTH    = 255,
   parameter int MAX_PENDING_BLANKS = 65535
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  mbxs_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output mbxs_pkg::rsp_word_type  rsp_data
);

   logic                req_fire;
   logic                burst_load;
   logic                slot_free;
   mbxs_pkg::burst_type burst;

   assign req_ready = slot_free;
   assign req_fire  = req_valid && slot_free;

   mbxs_line_parser #(
      .MAX_QUOTE_DEPTH   (MAX_QUOTE_DEPTH),
      .MAX_PENDING_BLANKS(MAX_PENDING_BLANKS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .burst_load(burst_load),
      .burst     (burst)
   );

   mbxs_result_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .burst_load(burst_load),
      .burst     (burst),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
